@@ design/assert_macros.svh @@
// Assertion macros used by the checker in ctpg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ctpg_pkg.sv @@
`timescale 1ns / 1ps

package ctpg_pkg;

    localparam int ANGLE_W    = 20;
    localparam int VEL_W      = 24;
    localparam int TIME_W     = 24;
    localparam int PERIOD_W   = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 88;
    localparam int S_BITS     = 30;
    localparam int US_PER_S   = 1000000;

    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DURATION  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_PERIOD = 4'd1;

    localparam logic [TIME_W-1:0]   MOVE_DURATION_RST  = 24'd1000000;
    localparam logic [PERIOD_W-1:0] CONTROL_PERIOD_RST = 20'd10000;

endpackage

@@ design/cubic_trajectory_point_generator_unit.sv @@
// Cubic trajectory point generator for one joint.
// Input channel s_*: one item holds start and end angle, start and end velocity
// and the elapsed time of the move. Output channel m_*: one item per input item
// with the spline angle at the clamped current time, one and two control periods
// ahead, and the velocity from the current to the next point, all saturated.
// The move duration and control period are to be written on the cfg_wr_* port
// only while no item is in flight; the block itself does not enforce this. They
// take effect for the next accepted item. Throughput is one item per clock while
// the output is not stalled. An item passes one input stage, a 30-step radix-2
// divider that forms the normalized time while a reciprocal multiply in its first
// three stages gives the span velocities, six stages that build the coefficients,
// evaluate and round the cubic and scale the position step, and a 24-step divider
// by the control period that gives the velocity. The whole pipeline advances on
// one enable; while m_tvalid is high and m_tready low it holds every stage and
// s_tready is low, so nothing is lost or repeated. Reset (aresetn low at a clock
// edge) empties the pipeline and restores the registers to 1000000 us and 10000 us.
`timescale 1ns / 1ps

module cubic_trajectory_point_generator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_angle, end_angle, start_velocity, end_velocity, elapsed_time
    input  logic [ctpg_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // target_position, next_position, second_next_position, target_velocity, zero pad
    output logic [ctpg_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ctpg_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [ctpg_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import ctpg_pkg::*;

    localparam int S_DIV = S_BITS;
    localparam int V_DIV = VEL_W;

    // One second in microseconds is 2^6 * 15625; the reciprocal is floor(2^44 / 15625).
    localparam int          DIV_15625   = 15625;
    localparam logic [30:0] RECIP_15625 = 31'd1125899906;

    typedef struct packed {
        logic [2:0]                full;
        logic [2:0][TIME_W-1:0]    rs;
        logic [2:0][S_BITS-1:0]    qs;
        logic [1:0][41:0]          xv;
        logic [1:0][S_BITS-1:0]    qv;
        logic [1:0]                neg;
        logic [ANGLE_W-1:0]        p0;
        logic [ANGLE_W-1:0]        p1;
    } sdiv_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]       rv;
        logic [VEL_W-1:0]          qv;
        logic                      ovf;
        logic                      neg;
        logic [2:0][ANGLE_W-1:0]   q;
    } vdiv_t;

    function automatic sdiv_t sdiv_step(input sdiv_t a, input logic [TIME_W-1:0] tlen,
                                        input int k);
        sdiv_t       r;
        logic [24:0] xs;
        logic [60:0] prod;
        r = a;
        for (int i = 0; i < 3; i++) begin
            xs = {a.rs[i], 1'b0};
            if (xs >= {1'b0, tlen}) begin
                r.rs[i] = 24'(xs - {1'b0, tlen});
                r.qs[i] = {a.qs[i][S_BITS-2:0], 1'b1};
            end else begin
                r.rs[i] = xs[23:0];
                r.qs[i] = {a.qs[i][S_BITS-2:0], 1'b0};
            end
        end
        // The span velocity quotient comes from the upper bits times the reciprocal.
        // That estimate is at most one short, so one remainder check finishes it.
        for (int i = 0; i < 2; i++) begin
            if (k == 0) begin
                prod    = 61'(a.xv[i][41:12]) * 61'(RECIP_15625);
                r.qv[i] = {1'b0, prod[60:32]};
            end else if (k == 1) begin
                r.xv[i] = 42'(a.xv[i] - 42'(a.qv[i]) * 42'(DIV_15625));
            end else if (k == 2) begin
                if (a.xv[i] >= 42'(DIV_15625)) begin
                    r.qv[i] = a.qv[i] + 30'd1;
                end
            end
        end
        return r;
    endfunction

    function automatic vdiv_t vdiv_step(input vdiv_t a, input logic [PERIOD_W-1:0] per);
        vdiv_t       r;
        logic [20:0] x;
        r = a;
        x = {a.rv, a.qv[VEL_W-1]};
        if (x >= {1'b0, per}) begin
            r.rv = 20'(x - {1'b0, per});
            r.qv = {a.qv[VEL_W-2:0], 1'b1};
        end else begin
            r.rv = x[19:0];
            r.qv = {a.qv[VEL_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [TIME_W-1:0]   move_duration_reg;
    logic [PERIOD_W-1:0] control_period_reg;

    logic en;

    // Input stage
    logic                      a_vld_reg;
    logic signed [ANGLE_W-1:0] a_p0_reg, a_p1_reg;
    logic signed [VEL_W-1:0]   a_v0_reg, a_v1_reg;
    logic [TIME_W-1:0]         a_run_reg;

    // Normalized time and span velocity division
    sdiv_t          div_reg [0:S_DIV];
    logic [S_DIV:0] dvld_reg;
    sdiv_t          div_init;

    // Cubic evaluation stages C, D, E, F, G and the velocity multiply H
    logic [5:0]                 mid_vld_reg;
    logic [2:0][30:0]           c_s_reg;
    logic signed [31:0]         c_v0_reg, c_b_reg, c_a_reg;
    logic signed [ANGLE_W-1:0]  c_p0_reg;
    logic [2:0][30:0]           c_s_next;
    logic signed [31:0]         c_v0_next, c_b_next, c_a_next;

    logic [2:0][30:0]           d_s_reg, d_s2_reg;
    logic signed [63:0]         d_pv_reg [0:2];
    logic signed [31:0]         d_b_reg, d_a_reg;
    logic signed [ANGLE_W-1:0]  d_p0_reg;

    logic [2:0][30:0]           e_s3_reg;
    logic signed [63:0]         e_pv_reg [0:2];
    logic signed [63:0]         e_pb_reg [0:2];
    logic signed [31:0]         e_a_reg;
    logic signed [ANGLE_W-1:0]  e_p0_reg;

    logic signed [63:0]         f_pa_reg [0:2];
    logic signed [63:0]         f_part_reg [0:2];

    logic [2:0][ANGLE_W-1:0]    g_q_reg;
    logic [2:0][ANGLE_W-1:0]    g_q_next;

    logic [40:0]                h_m_reg;
    logic                       h_neg_reg;
    logic [2:0][ANGLE_W-1:0]    h_q_reg;
    logic [40:0]                h_m_next;
    logic                       h_neg_next;

    // Velocity division
    vdiv_t          vdiv_reg [0:V_DIV];
    logic [V_DIV:0] vvld_reg;
    vdiv_t          vdiv_init;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [VEL_W-1:0]      vel_next;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Stage B: clamp the three times, start the span velocity products.
    always_comb begin
        logic [24:0] sum1;
        logic [25:0] sum2;
        logic [23:0] mag0, mag1;
        logic [47:0] n0, n1;
        div_init = '0;
        sum1 = {1'b0, a_run_reg} + {5'b0, control_period_reg};
        sum2 = {2'b0, a_run_reg} + {5'b0, control_period_reg, 1'b0};
        div_init.full[0] = a_run_reg >= move_duration_reg;
        div_init.full[1] = sum1 >= {1'b0, move_duration_reg};
        div_init.full[2] = sum2 >= {2'b0, move_duration_reg};
        div_init.rs[0]   = a_run_reg;
        div_init.rs[1]   = sum1[23:0];
        div_init.rs[2]   = sum2[23:0];
        mag0 = a_v0_reg[VEL_W-1] ? 24'(-a_v0_reg) : 24'(a_v0_reg);
        mag1 = a_v1_reg[VEL_W-1] ? 24'(-a_v1_reg) : 24'(a_v1_reg);
        n0 = 48'(mag0) * 48'(move_duration_reg) + 48'(US_PER_S / 2);
        n1 = 48'(mag1) * 48'(move_duration_reg) + 48'(US_PER_S / 2);
        div_init.xv[0]  = n0[47:6];
        div_init.xv[1]  = n1[47:6];
        div_init.neg[0] = a_v0_reg[VEL_W-1];
        div_init.neg[1] = a_v1_reg[VEL_W-1];
        div_init.p0     = a_p0_reg;
        div_init.p1     = a_p1_reg;
    end

    // Stage C: finish s and the span velocities, form the cubic coefficients.
    always_comb begin
        logic signed [31:0] vq0, vq1, p0w, p1w;
        for (int i = 0; i < 3; i++) begin
            c_s_next[i] = div_reg[S_DIV].full[i] ? 31'(1 << S_BITS)
                                                 : {1'b0, div_reg[S_DIV].qs[i]};
        end
        vq0 = $signed({2'b00, div_reg[S_DIV].qv[0]});
        vq1 = $signed({2'b00, div_reg[S_DIV].qv[1]});
        if (div_reg[S_DIV].neg[0]) vq0 = -vq0;
        if (div_reg[S_DIV].neg[1]) vq1 = -vq1;
        p0w = 32'($signed(div_reg[S_DIV].p0));
        p1w = 32'($signed(div_reg[S_DIV].p1));
        c_v0_next = vq0;
        c_b_next  = 3 * p1w - 3 * p0w - 2 * vq0 - vq1;
        c_a_next  = 2 * p0w - 2 * p1w + vq0 + vq1;
    end

    // Stage G: round to the nearest angle unit and saturate.
    always_comb begin
        logic signed [63:0] acc, sh;
        for (int i = 0; i < 3; i++) begin
            acc = f_part_reg[i] + f_pa_reg[i];
            sh  = acc >>> S_BITS;
            if (sh > 64'sd524287) begin
                g_q_next[i] = 20'h7FFFF;
            end else if (sh < -64'sd524288) begin
                g_q_next[i] = 20'h80000;
            end else begin
                g_q_next[i] = sh[ANGLE_W-1:0];
            end
        end
    end

    // Stage H: magnitude of the position step times one second in microseconds.
    always_comb begin
        logic signed [20:0] d;
        logic [20:0]        mag;
        d = $signed({g_q_reg[1][ANGLE_W-1], g_q_reg[1]})
          - $signed({g_q_reg[0][ANGLE_W-1], g_q_reg[0]});
        mag = d[20] ? 21'(-d) : 21'(d);
        h_neg_next = d[20];
        h_m_next   = 41'(mag) * 41'(US_PER_S);
    end

    // Rounding by half the period turns the division into a plain floor.
    always_comb begin
        logic [40:0] n;
        n = h_m_reg + 41'(control_period_reg >> 1);
        vdiv_init.ovf = {3'b000, n[40:VEL_W]} >= control_period_reg;
        vdiv_init.rv  = {3'b000, n[40:VEL_W]};
        vdiv_init.qv  = n[VEL_W-1:0];
        vdiv_init.neg = h_neg_reg;
        vdiv_init.q   = h_q_reg;
    end

    always_comb begin
        logic [VEL_W-1:0] q;
        q = vdiv_reg[V_DIV].qv;
        if (control_period_reg == '0) begin
            vel_next = '0;
        end else if (vdiv_reg[V_DIV].neg) begin
            vel_next = (vdiv_reg[V_DIV].ovf || q > 24'h800000) ? 24'h800000 : 24'(~q + 24'd1);
        end else begin
            vel_next = (vdiv_reg[V_DIV].ovf || q > 24'h7FFFFF) ? 24'h7FFFFF : q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_duration_reg  <= MOVE_DURATION_RST;
            control_period_reg <= CONTROL_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MOVE_DURATION:  move_duration_reg  <= cfg_wr_data[TIME_W-1:0];
                REG_CONTROL_PERIOD: control_period_reg <= cfg_wr_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg    <= 1'b0;
            dvld_reg     <= '0;
            mid_vld_reg  <= '0;
            vvld_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg    <= s_tvalid;
            dvld_reg     <= {dvld_reg[S_DIV-1:0], a_vld_reg};
            mid_vld_reg  <= {mid_vld_reg[4:0], dvld_reg[S_DIV]};
            vvld_reg     <= {vvld_reg[V_DIV-1:0], mid_vld_reg[5]};
            m_tvalid_reg <= vvld_reg[V_DIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_p0_reg  <= $signed(s_tdata[19:0]);
            a_p1_reg  <= $signed(s_tdata[39:20]);
            a_v0_reg  <= $signed(s_tdata[63:40]);
            a_v1_reg  <= $signed(s_tdata[87:64]);
            a_run_reg <= s_tdata[111:88];

            div_reg[0] <= div_init;
            for (int k = 0; k < S_DIV; k++) begin
                div_reg[k+1] <= sdiv_step(div_reg[k], move_duration_reg, k);
            end

            c_s_reg  <= c_s_next;
            c_v0_reg <= c_v0_next;
            c_b_reg  <= c_b_next;
            c_a_reg  <= c_a_next;
            c_p0_reg <= $signed(div_reg[S_DIV].p0);

            for (int i = 0; i < 3; i++) begin
                d_s2_reg[i] <= 31'((64'(c_s_reg[i]) * 64'(c_s_reg[i])) >> S_BITS);
                d_pv_reg[i] <= 64'(c_v0_reg) * 64'($signed({1'b0, c_s_reg[i]}));
            end
            d_s_reg  <= c_s_reg;
            d_b_reg  <= c_b_reg;
            d_a_reg  <= c_a_reg;
            d_p0_reg <= c_p0_reg;

            for (int i = 0; i < 3; i++) begin
                e_s3_reg[i] <= 31'((64'(d_s2_reg[i]) * 64'(d_s_reg[i])) >> S_BITS);
                e_pb_reg[i] <= 64'(d_b_reg) * 64'($signed({1'b0, d_s2_reg[i]}));
                e_pv_reg[i] <= d_pv_reg[i];
            end
            e_a_reg  <= d_a_reg;
            e_p0_reg <= d_p0_reg;

            for (int i = 0; i < 3; i++) begin
                f_pa_reg[i]   <= 64'(e_a_reg) * 64'($signed({1'b0, e_s3_reg[i]}));
                f_part_reg[i] <= (64'(e_p0_reg) <<< S_BITS) + e_pv_reg[i] + e_pb_reg[i]
                               + (64'sd1 <<< (S_BITS - 1));
            end

            g_q_reg <= g_q_next;

            h_m_reg   <= h_m_next;
            h_neg_reg <= h_neg_next;
            h_q_reg   <= g_q_reg;

            vdiv_reg[0] <= vdiv_init;
            for (int k = 0; k < V_DIV; k++) begin
                vdiv_reg[k+1] <= vdiv_step(vdiv_reg[k], control_period_reg);
            end

            m_tdata_reg <= {4'b0000, vel_next, vdiv_reg[V_DIV].q[2],
                            vdiv_reg[V_DIV].q[1], vdiv_reg[V_DIV].q[0]};
        end
    end

endmodule

@@ design/ctpg_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctpg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ctpg_pkg::M_TDATA_W-1:0] m_tdata
);
    import ctpg_pkg::*;

    // A stalled result keeps its valid and its data.
    `ASSERT_ON(a_out_valid_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `ASSERT_ON(a_out_data_holds, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "m_tdata changed while stalled")

    // The pipeline shares one enable, so a stalled output must hold off the input.
    `ASSERT_ON(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready |-> !s_tready, "item taken while output stalled")

    // Reset empties the pipeline.
    `ASSERT_ANY(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result shown right after reset")

endmodule

bind cubic_trajectory_point_generator_unit ctpg_checker u_ctpg_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ctpg_pkg::*;

    localparam int LATENCY    = 63;
    localparam int WDOG_LIMIT = 40000;
    localparam logic [CFG_IDX_W-1:0] REG_ABSENT = 4'd7;

    typedef struct packed {
        logic [VEL_W-1:0]   velocity;
        logic [ANGLE_W-1:0] second_next;
        logic [ANGLE_W-1:0] next;
        logic [ANGLE_W-1:0] target;
    } point_t;

    typedef struct {
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] end_angle;
        logic [VEL_W-1:0]   start_vel;
        logic [VEL_W-1:0]   end_vel;
        logic [TIME_W-1:0]  elapsed;
        bit                 typed;
        point_t             want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    cubic_trajectory_point_generator_unit dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    longint move_us = 1000000;
    longint period_us = 10000;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit long_stall_req = 1'b0;
    int errors = 0;
    int wdog = 0;
    point_t points_due[$];
    bit typed_due[$];
    point_t typed_want[$];

    function automatic longint clip(longint v, int w);
        longint hi = (longint'(1) <<< (w - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    // Velocity times move duration, as angle units over the whole move.
    function automatic longint span_angle(longint v, longint dur);
        longint q = ((v < 0 ? -v : v) * dur + US_PER_S / 2) / US_PER_S;
        return v < 0 ? -q : q;
    endfunction

    function automatic longint cubic_at(longint t, longint dur, longint p0, longint c1,
                                        longint c2, longint c3);
        longint s, s2, s3, acc;
        s = (dur == 0) ? (longint'(1) <<< S_BITS) : (t <<< S_BITS) / dur;
        s2 = (s * s) >>> S_BITS;
        s3 = (s2 * s) >>> S_BITS;
        acc = (p0 <<< S_BITS) + c1 * s + c2 * s2 + c3 * s3;
        return clip((acc + (longint'(1) <<< (S_BITS - 1))) >>> S_BITS, ANGLE_W);
    endfunction

    function automatic point_t trajectory_point(logic [S_TDATA_W-1:0] d);
        longint p0, p1, c0, c1, c2, c3, run, t0, t1, t2, q0, q1, q2, dq, mag, vel;
        point_t r;
        p0 = longint'($signed(d[19:0]));
        p1 = longint'($signed(d[39:20]));
        c0 = span_angle(longint'($signed(d[63:40])), move_us);
        c1 = span_angle(longint'($signed(d[87:64])), move_us);
        run = longint'(d[111:88]);
        c2 = 3 * p1 - 3 * p0 - 2 * c0 - c1;
        c3 = 2 * p0 - 2 * p1 + c0 + c1;
        t0 = run < move_us ? run : move_us;
        t1 = run + period_us < move_us ? run + period_us : move_us;
        t2 = run + 2 * period_us < move_us ? run + 2 * period_us : move_us;
        q0 = cubic_at(t0, move_us, p0, c0, c2, c3);
        q1 = cubic_at(t1, move_us, p0, c0, c2, c3);
        q2 = cubic_at(t2, move_us, p0, c0, c2, c3);
        vel = 0;
        if (period_us != 0) begin
            dq = q1 - q0;
            mag = (2 * (dq < 0 ? -dq : dq) * US_PER_S + period_us) / (2 * period_us);
            vel = clip(dq < 0 ? -mag : mag, VEL_W);
        end
        r.target = q0[ANGLE_W-1:0];
        r.next = q1[ANGLE_W-1:0];
        r.second_next = q2[ANGLE_W-1:0];
        r.velocity = vel[VEL_W-1:0];
        return r;
    endfunction

    // Input monitor: predict at the accepting edge, config is frozen meanwhile.
    always @(posedge aclk) begin
        point_t p;
        if (aresetn && s_tvalid && s_tready) begin
            p = trajectory_point(s_tdata);
            if (typed_due.pop_front()) begin
                p = typed_want.pop_front();
            end
            points_due.push_back(p);
        end
    end

    always @(posedge aclk) begin
        point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[ANGLE_W*3+VEL_W-1:0];
            if (points_due.size() == 0) begin
                $error("unexpected item on output: %h", m_tdata);
                errors++;
            end else begin
                want = points_due.pop_front();
                if (got.target !== want.target) begin
                    $error("target_position exp %h got %h", want.target, got.target);
                    errors++;
                end
                if (got.next !== want.next) begin
                    $error("next_position exp %h got %h", want.next, got.next);
                    errors++;
                end
                if (got.second_next !== want.second_next) begin
                    $error("second_next_position exp %h got %h",
                           want.second_next, got.second_next);
                    errors++;
                end
                if (got.velocity !== want.velocity) begin
                    $error("target_velocity exp %h got %h", want.velocity, got.velocity);
                    errors++;
                end
                if (m_tdata[M_TDATA_W-1:ANGLE_W*3+VEL_W] !== '0) begin
                    $error("pad exp 0 got %h", m_tdata[M_TDATA_W-1:ANGLE_W*3+VEL_W]);
                    errors++;
                end
            end
        end
    end

    // Receiver; a requested long stall lets the pipeline fill and back up.
    always @(posedge aclk) begin
        int hold;
        if (long_stall_req && hold == 0) begin
            hold = 400;
            long_stall_req = 1'b0;
        end
        if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    task automatic send_item(row_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        typed_due.push_back(r.typed);
        if (r.typed) begin
            typed_want.push_back(r.want);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.elapsed, r.end_vel, r.start_vel, r.end_angle, r.start_angle};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (points_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    // The enable drops after the write edge and stays low until the task returns.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MOVE_DURATION) begin
            move_us = val & 24'hFFFFFF;
        end else if (idx == REG_CONTROL_PERIOD) begin
            period_us = val & 20'hFFFFF;
        end
        @(posedge aclk);
    endtask

    function automatic row_t random_row();
        row_t r;
        int k;
        r.start_angle = ANGLE_W'($urandom);
        r.end_angle = ANGLE_W'($urandom);
        r.start_vel = VEL_W'($urandom);
        r.end_vel = VEL_W'($urandom);
        k = $urandom_range(9);
        // Small velocities keep the curve in range most of the time.
        if (k < 5) begin
            r.start_vel = {{8{r.start_vel[15]}}, r.start_vel[15:0]};
            r.end_vel = {{8{r.end_vel[15]}}, r.end_vel[15:0]};
        end
        k = $urandom_range(9);
        if (k < 7 && move_us > 0) begin
            r.elapsed = TIME_W'($urandom_range(32'(move_us)));
        end else if (k < 9) begin
            r.elapsed = TIME_W'(move_us + $urandom_range(3 * 32'(period_us)));
        end else begin
            r.elapsed = TIME_W'($urandom);
        end
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t row(int p0, int p1, int v0, int v1, int run, bit at_end);
        row_t r;
        r.start_angle = ANGLE_W'(p0);
        r.end_angle = ANGLE_W'(p1);
        r.start_vel = VEL_W'(v0);
        r.end_vel = VEL_W'(v1);
        r.elapsed = TIME_W'(run);
        r.typed = at_end;
        // Past the end every point sits exactly on the end angle.
        r.want = '{velocity: '0, second_next: r.end_angle, next: r.end_angle,
                   target: r.end_angle};
        return r;
    endfunction

    row_t plan[$];
    longint durations[6] = '{1000000, 1000, 16777215, 1, 0, 500000};
    longint periods[6] = '{10000, 10, 1000000, 1, 0, 0};

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        plan.push_back(row(-524288, 524287, 0, 0, 0, 0));
        plan.push_back(row(524287, -524288, 0, 0, 0, 0));
        plan.push_back(row(-524288, 524287, 0, 0, 1000000, 1));
        plan.push_back(row(524287, -524288, 0, 0, 16777215, 1));
        plan.push_back(row(0, 1000, -8388608, 8388607, 2000000, 1));
        plan.push_back(row(0, 0, 8388607, -8388608, 500000, 0));
        plan.push_back(row(0, 0, -8388608, -8388608, 500000, 0));
        plan.push_back(row(-524288, -524288, 8388607, 8388607, 250000, 0));
        plan.push_back(row(524287, 524287, -8388608, 8388607, 750000, 0));
        plan.push_back(row(100, -100, 65536, -65536, 995000, 0));
        plan.push_back(row(100, -100, 65536, -65536, 985000, 0));
        plan.push_back(row(-1, 1, -1, 1, 999999, 0));
        plan.push_back(row(0, 65536, 0, 0, 500000, 0));
        plan.push_back(row(0, -65536, 0, 0, 16777215, 1));
        plan.push_back(row(1, -1, 8388607, 8388607, 0, 0));
        foreach (plan[i]) send_item(plan[i]);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_MOVE_DURATION, durations[ph]);
            write_reg(REG_CONTROL_PERIOD, periods[ph]);
            if (ph == 3) begin
                // Writes to a missing register must leave both in place.
                cfg_wr_en <= 1'b1;
                cfg_wr_index <= REG_ABSENT;
                cfg_wr_data <= '1;
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
            end
            if (ph == 4) begin
                send_item(row(-524288, 524287, 0, 0, 0, 1));
                send_item(row(524287, -524288, 8388607, -8388608, 12345, 1));
            end
            for (int m = 0; m < 4; m++) begin
                src_idle_pct = (m == 1 || m == 3) ? (m == 1 ? 79 : 16) : 0;
                sink_stall_pct = (m == 2 || m == 3) ? (m == 2 ? 79 : 16) : 0;
                if (ph == 1 && m == 0) begin
                    long_stall_req = 1'b1;
                end
                repeat (56) send_item(random_row());
            end
            drain();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/ctpg_pkg.sv
design/cubic_trajectory_point_generator_unit.sv
design/ctpg_checker.sv
dv/tb_top.sv
